[rtl/mnva_pkg.sv]
// ----------------------------------------------------------------------------
// MIDI note voice allocator package
// Shared types and constants for the voice allocator modules.
// ----------------------------------------------------------------------------
package mnva_pkg;

    localparam int BYTE_W     = 8;
    localparam int NOTE_W     = 7;
    localparam int DRIVE_W    = 5;
    localparam int KIND_W     = 2;
    localparam int TDATA_W    = 16;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;

    // status[6:4] for note-on (0x9n) and note-off (0x8n)
    localparam logic [2:0] OP_NOTE_ON  = 3'h1;
    localparam logic [2:0] OP_NOTE_OFF = 3'h0;

    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO = 2'd0,
        KIND_ON   = 2'd1,
        KIND_OFF  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WR_MAIN,
        ST_WR_MIRROR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   value;
        logic [DRIVE_W-1:0]  drive;
        logic                last;
    } t_result;

endpackage

[rtl/mnva_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mnva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/mnva_ctrl.sv]
// ----------------------------------------------------------------------------
// Voice allocator control
// Message parser, note table scan and update, result staging.
// ----------------------------------------------------------------------------
module mnva_ctrl #(
    parameter int DRIVES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [mnva_pkg::BYTE_W-1:0] i_in_byte,
    output logic                        o_push_valid,
    input  logic                        i_push_ready,
    output mnva_pkg::t_result           o_push
);
    import mnva_pkg::*;

    localparam int AW   = $clog2(DRIVES);
    localparam int CW   = $clog2(DRIVES + 1);
    localparam int HALF = DRIVES / 2;

    t_state              r_state, n_state;
    logic [1:0]          r_held, n_held;
    logic [BYTE_W-1:0]   r_status, n_status;
    logic [NOTE_W-1:0]   r_note, n_note;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic                r_alloc, n_alloc;
    logic                r_stereo;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_chk_v, n_chk_v;
    logic [AW-1:0]       r_chk_a, n_chk_a;
    logic [AW-1:0]       r_hit, n_hit;
    logic [DRIVES-1:0]   r_valid, n_valid;
    t_result             r_res [3];
    t_result             n_res [3];
    logic [1:0]          r_res_n, n_res_n;
    logic [1:0]          r_res_i, n_res_i;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [NOTE_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [NOTE_W-1:0]   ram_rdata;

    logic [CW-1:0]       limit;
    logic                issue;
    logic [NOTE_W-1:0]   entry;
    logic [NOTE_W-1:0]   target;
    logic                mirror;
    logic [AW-1:0]       mirror_a;
    logic [2:0]          op;

    function automatic t_result echo_res(input logic [BYTE_W-1:0] v);
        t_result r;
        r = '{kind: KIND_ECHO, value: v, drive: '0, last: 1'b0};
        return r;
    endfunction

    mnva_ram #(
        .WIDTH(NOTE_W),
        .DEPTH(DRIVES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_addr[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign op         = r_status[6:4];
    assign limit      = (r_alloc && r_stereo) ? CW'(HALF) : CW'(DRIVES);
    assign issue      = (r_addr < limit);
    assign entry      = r_valid[r_chk_a] ? ram_rdata : '0;
    assign target     = r_alloc ? '0 : r_note;
    assign mirror     = r_stereo && (CW'(r_hit) < CW'(HALF));
    assign mirror_a   = AW'(CW'(r_hit) + CW'(HALF));

    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_status  = r_status;
        n_note    = r_note;
        n_byte    = r_byte;
        n_alloc   = r_alloc;
        n_addr    = r_addr;
        n_chk_v   = 1'b0;
        n_chk_a   = r_chk_a;
        n_hit     = r_hit;
        n_valid   = r_valid;
        n_res     = r_res;
        n_res_n   = r_res_n;
        n_res_i   = r_res_i;
        ram_we    = 1'b0;
        ram_waddr = r_hit;
        ram_wdata = r_alloc ? r_note : '0;
        ram_re    = 1'b0;
        o_push_valid = 1'b0;
        o_push       = r_res[r_res_i];
        o_push.last  = (r_res_i == r_res_n - 2'd1);

        case (r_state)
            ST_IDLE: begin
                n_res_i = '0;
                n_addr  = '0;
                if (i_in_valid) begin
                    case (r_held)
                        2'd0: begin
                            if (!i_in_byte[7]) begin
                                n_res[0] = echo_res(i_in_byte);
                                n_res_n  = 2'd1;
                                n_state  = ST_EMIT;
                            end else begin
                                n_status = i_in_byte;
                                n_held   = 2'd1;
                            end
                        end
                        2'd1: begin
                            if (i_in_byte[7]) begin
                                n_res[0] = echo_res(r_status);
                                n_res[1] = echo_res(i_in_byte);
                                n_res_n  = 2'd2;
                                n_held   = 2'd0;
                                n_state  = ST_EMIT;
                            end else begin
                                n_note = i_in_byte[NOTE_W-1:0];
                                n_held = 2'd2;
                            end
                        end
                        default: begin
                            n_held = 2'd0;
                            n_byte = i_in_byte;
                            if (!i_in_byte[7] && r_note != '0 &&
                                (op == OP_NOTE_ON || op == OP_NOTE_OFF)) begin
                                n_alloc = (op == OP_NOTE_ON);
                                n_state = ST_SEARCH;
                            end else begin
                                n_res[0] = echo_res(r_status);
                                n_res[1] = echo_res({1'b0, r_note});
                                n_res[2] = echo_res(i_in_byte);
                                n_res_n  = 2'd3;
                                n_state  = ST_EMIT;
                            end
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // one read issued per cycle, compared in the cycle after
                ram_re  = issue;
                n_addr  = r_addr + CW'(issue);
                n_chk_v = issue;
                n_chk_a = r_addr[AW-1:0];
                if (r_chk_v && entry == target) begin
                    n_hit   = r_chk_a;
                    n_state = ST_WR_MAIN;
                end else if (r_chk_v && r_chk_a == AW'(limit - CW'(1))) begin
                    n_res[0] = echo_res(r_status);
                    n_res[1] = echo_res({1'b0, r_note});
                    n_res[2] = echo_res(r_byte);
                    n_res_n  = 2'd3;
                    n_state  = ST_EMIT;
                end
            end
            ST_WR_MAIN: begin
                ram_we         = 1'b1;
                n_valid[r_hit] = 1'b1;
                n_res[0] = '{kind:  r_alloc ? KIND_ON : KIND_OFF,
                             value: {1'b0, r_note},
                             drive: DRIVE_W'(r_hit) + DRIVE_W'(1),
                             last:  1'b0};
                n_res[1] = '{kind:  r_alloc ? KIND_ON : KIND_OFF,
                             value: {1'b0, r_note},
                             drive: DRIVE_W'(r_hit) + DRIVE_W'(HALF + 1),
                             last:  1'b0};
                n_res_n  = mirror ? 2'd2 : 2'd1;
                n_state  = mirror ? ST_WR_MIRROR : ST_EMIT;
            end
            ST_WR_MIRROR: begin
                ram_we            = 1'b1;
                ram_waddr         = mirror_a;
                n_valid[mirror_a] = 1'b1;
                n_state           = ST_EMIT;
            end
            ST_EMIT: begin
                o_push_valid = 1'b1;
                if (i_push_ready) begin
                    if (o_push.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_res_i = r_res_i + 2'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_held   <= '0;
            r_stereo <= 1'b0;
            r_valid  <= '0;
            r_chk_v  <= 1'b0;
            r_res_i  <= '0;
            r_res_n  <= '0;
            r_addr   <= '0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_valid  <= n_valid;
            r_chk_v  <= n_chk_v;
            r_res_i  <= n_res_i;
            r_res_n  <= n_res_n;
            r_addr   <= n_addr;
            if (i_cfg_valid) begin
                r_stereo <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_note   <= n_note;
        r_byte   <= n_byte;
        r_alloc  <= n_alloc;
        r_chk_a  <= n_chk_a;
        r_hit    <= n_hit;
        r_res    <= n_res;
    end

endmodule

[rtl/mnva_outq.sv]
// ----------------------------------------------------------------------------
// Result queue
// Small FIFO between the control and the output stream.
// ----------------------------------------------------------------------------
module mnva_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  mnva_pkg::t_result i_push,
    output logic              o_valid,
    input  logic              i_ready,
    output mnva_pkg::t_result o_data
);
    import mnva_pkg::*;

    localparam int CNT_W = OUTQ_AW + 1;

    t_result              r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   r_wp, n_wp;
    logic [OUTQ_AW-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 push;
    logic                 pop;

    assign o_push_ready = (r_cnt != CNT_W'(OUTQ_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_data       = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_valid && i_ready;

    always_comb begin
        n_wp  = r_wp + OUTQ_AW'(push);
        n_rp  = r_rp + OUTQ_AW'(pop);
        n_cnt = r_cnt + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push;
        end
    end

endmodule

[rtl/midi_note_voice_allocator_top.sv]
// ----------------------------------------------------------------------------
// MIDI note voice allocator
// Parses a MIDI byte stream and assigns note-on/off to drives.
// ----------------------------------------------------------------------------
// Input stream: one MIDI byte per request on s_axis. Output stream: one
// result per request on m_axis, tuser = kind (echo, note on, note off),
// tdata = value and drive, tlast marks the final result of an input byte.
// Config: i_cfg_valid/i_cfg_data writes stereo mode; o_cfg_ready is always
// high. Write it only while no byte is in flight.
// A byte that gives results holds off the next byte until each result has
// been pushed to the queue. A completed note message scans the note table
// RAM, one entry per cycle through its registered read port, then on a hit
// writes one or two entries. s_axis_tready is high only while the control
// waits for a byte.
// Results go through a 4-entry queue, so a stalled receiver holds back the
// input only once the queue is full.
// Reset (synchronous, active low) empties the queue, drops any partial
// message, marks every drive free and clears stereo mode.
// ----------------------------------------------------------------------------
module midi_note_voice_allocator_top #(
    parameter int DRIVES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] value, [12:8] drive, [15:13] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import mnva_pkg::*;

    logic    push_valid;
    logic    push_ready;
    t_result push_data;
    t_result head;

    assign o_cfg_ready = 1'b1;

    mnva_ctrl #(
        .DRIVES(DRIVES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .o_push_valid(push_valid),
        .i_push_ready(push_ready),
        .o_push      (push_data)
    );

    mnva_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(push_valid),
        .o_push_ready(push_ready),
        .i_push      (push_data),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (head)
    );

    assign m_axis_tdata = {(TDATA_W - BYTE_W - DRIVE_W)'(0), head.drive, head.value};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

[rtl/mnva_chk.sv]
// ----------------------------------------------------------------------------
// Voice allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module mnva_chk #(
    parameter int DRIVES = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import mnva_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_echo_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ECHO |-> m_axis_tdata[12:8] == 5'd0)
        else $error("echoed byte carries a drive");

    a_drive_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_ECHO |->
            m_axis_tdata[12:8] != 5'd0 && m_axis_tdata[12:8] <= 5'(DRIVES) &&
            !m_axis_tdata[7] && m_axis_tdata[6:0] != 7'd0)
        else $error("bad drive event");

endmodule

bind midi_note_voice_allocator_top mnva_chk #(.DRIVES(DRIVES)) u_mnva_chk (.*);

[bench/tb_midi_note_voice_allocator_top.sv]
// ----------------------------------------------------------------------------
// Voice allocator regression bench
// Drives MIDI byte streams through the allocator and checks every result.
// The bench predicts message framing, drive allocation and release with
// echo, mono and stereo. A short directed table comes first, followed by
// random phases of mostly well-formed messages. Sender bursts and receiver
// stalls are random throughout.
// ----------------------------------------------------------------------------
module tb_midi_note_voice_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mnva_pkg::*;

    localparam int DRIVES      = 8;
    localparam int HALF        = DRIVES / 2;
    localparam int SETTLE      = 2 * (DRIVES + 8);
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] rx;
        int         n_typed;   // -1: predicted
    } stim_row_t;

    localparam stim_row_t STIM_TAB [26] = '{
        '{8'h00, 1}, '{8'h7F, 1},
        '{8'h9F, -1}, '{8'h7F, -1}, '{8'h00, 1},
        '{8'h90, -1}, '{8'h01, -1}, '{8'h7F, 1},
        '{8'h8F, -1}, '{8'h7F, -1}, '{8'h40, 1},
        '{8'h80, -1}, '{8'h05, -1}, '{8'h00, 3},
        '{8'h90, -1}, '{8'h00, -1}, '{8'h10, 3},
        '{8'hFF, -1}, '{8'hB0, 2}, '{8'h12, 1},
        '{8'hB3, -1}, '{8'h07, -1}, '{8'h64, 3},
        '{8'hC0, -1}, '{8'h10, -1}, '{8'h80, 3}
    };

    localparam t_result TYPED_RES [20] = '{
        '{KIND_ECHO, 8'h00, 5'd0, 1'b1},
        '{KIND_ECHO, 8'h7F, 5'd0, 1'b1},
        '{KIND_ON,   8'h7F, 5'd1, 1'b1},
        '{KIND_ON,   8'h01, 5'd2, 1'b1},
        '{KIND_OFF,  8'h7F, 5'd1, 1'b1},
        '{KIND_ECHO, 8'h80, 5'd0, 1'b0},
        '{KIND_ECHO, 8'h05, 5'd0, 1'b0},
        '{KIND_ECHO, 8'h00, 5'd0, 1'b1},
        '{KIND_ECHO, 8'h90, 5'd0, 1'b0},
        '{KIND_ECHO, 8'h00, 5'd0, 1'b0},
        '{KIND_ECHO, 8'h10, 5'd0, 1'b1},
        '{KIND_ECHO, 8'hFF, 5'd0, 1'b0},
        '{KIND_ECHO, 8'hB0, 5'd0, 1'b1},
        '{KIND_ECHO, 8'h12, 5'd0, 1'b1},
        '{KIND_ECHO, 8'hB3, 5'd0, 1'b0},
        '{KIND_ECHO, 8'h07, 5'd0, 1'b0},
        '{KIND_ECHO, 8'h64, 5'd0, 1'b1},
        '{KIND_ECHO, 8'hC0, 5'd0, 1'b0},
        '{KIND_ECHO, 8'h10, 5'd0, 1'b0},
        '{KIND_ECHO, 8'h80, 5'd0, 1'b1}
    };

    localparam logic PHASE_STEREO [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    // allocator state as seen by the bench
    logic       stereo_q = 1'b0;
    logic [1:0] held_cnt = 2'd0;
    logic [7:0] status_q = 8'h00;
    logic [6:0] note_q = 7'h00;
    logic [6:0] drive_note [DRIVES];

    t_result step_res [3];
    int      step_cnt;
    t_result pending_results [$];

    int typed_cnt = -1;
    int typed_ptr = 0;
    int fail_count = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;

    logic [7:0] stall_pat = 8'hFF;
    logic [5:0] stall_age = 6'd0;

    midi_note_voice_allocator_top #(
        .DRIVES(DRIVES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        foreach (drive_note[i]) drive_note[i] = 7'h00;
    end

    // ---------------- predictor ----------------
    task automatic add_result(input t_kind kind, input logic [7:0] value, input int drive);
        step_res[step_cnt] = '{kind, value, drive[4:0], 1'b0};
        step_cnt++;
    endtask

    task automatic echo_message(input logic [7:0] b);
        add_result(KIND_ECHO, status_q, 0);
        add_result(KIND_ECHO, {1'b0, note_q}, 0);
        add_result(KIND_ECHO, b, 0);
    endtask

    task automatic play_message(input logic [7:0] vel);
        logic [2:0] op;
        logic [6:0] n;
        bit         done;
        op = status_q[6:4];
        n = note_q;
        done = 0;
        if (op == OP_NOTE_ON && n != 0) begin
            for (int i = 0; i < (stereo_q ? HALF : DRIVES); i++) begin
                if (!done && drive_note[i] == 0) begin
                    drive_note[i] = n;
                    add_result(KIND_ON, {1'b0, n}, i + 1);
                    if (stereo_q) begin
                        drive_note[i + HALF] = n;
                        add_result(KIND_ON, {1'b0, n}, i + 1 + HALF);
                    end
                    done = 1;
                end
            end
        end else if ((op == OP_NOTE_ON || op == OP_NOTE_OFF) && n != 0) begin
            for (int i = 0; i < DRIVES; i++) begin
                if (!done && drive_note[i] == n) begin
                    drive_note[i] = 0;
                    add_result(KIND_OFF, {1'b0, n}, i + 1);
                    if (stereo_q && i < HALF) begin
                        drive_note[i + HALF] = 0;
                        add_result(KIND_OFF, {1'b0, n}, i + 1 + HALF);
                    end
                    done = 1;
                end
            end
        end
        if (!done) echo_message(vel);
    endtask

    task automatic voice_step(input logic [7:0] b);
        step_cnt = 0;
        if (held_cnt == 0) begin
            if (!b[7]) begin
                add_result(KIND_ECHO, b, 0);
            end else begin
                status_q = b;
                held_cnt = 1;
            end
        end else if (held_cnt == 1) begin
            if (b[7]) begin
                held_cnt = 0;
                add_result(KIND_ECHO, status_q, 0);
                add_result(KIND_ECHO, b, 0);
            end else begin
                note_q = b[6:0];
                held_cnt = 2;
            end
        end else begin
            held_cnt = 0;
            if (b[7]) echo_message(b);
            else play_message(b);
        end
        if (step_cnt > 0) step_res[step_cnt - 1].last = 1'b1;
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 40)
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) stereo_q = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                voice_step(s_axis_tdata);
                if (typed_cnt < 0) begin
                    for (int k = 0; k < step_cnt; k++) pending_results.push_back(step_res[k]);
                end else begin
                    for (int k = 0; k < typed_cnt; k++) begin
                        pending_results.push_back(TYPED_RES[typed_ptr]);
                        typed_ptr++;
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, value", m_axis_tdata[7:0], 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser != want.kind)
                        report_mismatch("kind", m_axis_tuser, want.kind);
                    if (m_axis_tdata[7:0] != want.value)
                        report_mismatch("value", m_axis_tdata[7:0], want.value);
                    if (m_axis_tdata[12:8] != want.drive)
                        report_mismatch("drive", m_axis_tdata[12:8], want.drive);
                    if (m_axis_tlast != want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                end
            end
        end
    end

    // receiver stalls on a pattern that is redrawn whenever stall_age wraps to zero
    always @(posedge i_clk) begin
        if (stall_age == 0) begin
            if ($urandom_range(0, 3) == 0) stall_pat <= 8'hFF;
            else stall_pat <= 8'h01 | 8'($urandom);
        end
        stall_age <= stall_age + 1'b1;
        m_axis_tready <= stall_pat[stall_age[2:0]];
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("midi_note_voice_allocator_top regression: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_byte(input logic [7:0] b, input int n_typed);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        typed_cnt <= n_typed;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 40);
            else burst_left = $urandom_range(0, 6);
        end
    endtask

    task automatic send_message(input logic [7:0] st, input logic [6:0] d1,
                                input logic [6:0] d2);
        send_byte(st, -1);
        send_byte({1'b0, d1}, -1);
        send_byte({1'b0, d2}, -1);
    endtask

    function automatic logic [6:0] pick_note();
        if ($urandom_range(0, 9) < 7) return 7'($urandom_range(1, 8));
        return 7'($urandom_range(1, 127));
    endfunction

    task automatic send_random_traffic(input int n_bytes);
        int         r;
        int         stop_at;
        logic [3:0] ch;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 99);
            ch = 4'($urandom_range(0, 15));
            if (r < 40)
                send_message({1'b1, OP_NOTE_ON, ch}, pick_note(), 7'($urandom_range(0, 127)));
            else if (r < 65)
                send_message({1'b1, OP_NOTE_OFF, ch}, pick_note(), 7'($urandom_range(0, 127)));
            else if (r < 72)
                send_message({1'b1, ($urandom_range(0, 1) ? OP_NOTE_ON : OP_NOTE_OFF), ch},
                             7'h00, 7'($urandom_range(0, 127)));
            else if (r < 82)
                send_message(8'($urandom_range(8'hA0, 8'hFF)), 7'($urandom_range(0, 127)),
                             7'($urandom_range(0, 127)));
            else if (r < 90)
                send_byte(8'($urandom_range(0, 127)), -1);
            else if (r < 95) begin
                send_byte(8'($urandom_range(128, 255)), -1);
                send_byte(8'($urandom_range(128, 255)), -1);
            end else begin
                send_byte(8'($urandom_range(128, 255)), -1);
                send_byte(8'($urandom_range(0, 127)), -1);
                send_byte(8'($urandom_range(128, 255)), -1);
            end
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_stereo(input logic v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (STIM_TAB[r]) send_byte(STIM_TAB[r].rx, STIM_TAB[r].n_typed);
        foreach (PHASE_STEREO[p]) begin
            write_stereo(PHASE_STEREO[p]);
            send_random_traffic(61);
        end
        wait_idle();
        if (fail_count == 0)
            $display("midi_note_voice_allocator_top regression: pass");
        else
            $display("midi_note_voice_allocator_top regression: fail");
        $finish;
    end

endmodule
